// ===== src/kjpc_pkg.sv =====
package kjpc_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_MS_TICK    = 2'd0;
  localparam logic [1:0] OP_KICK       = 2'd1;
  localparam logic [1:0] OP_FORCED     = 2'd2;
  localparam logic [1:0] OP_PULSE_TICK = 2'd3;

  // register indexes, paddr[3:2]
  localparam logic [1:0] REG_MIN_GAP   = 2'd0;
  localparam logic [1:0] REG_EXPIRE    = 2'd1;
  localparam logic [1:0] REG_VWINDOW   = 2'd2;
  localparam logic [1:0] REG_MAX_KICK  = 2'd3;

  localparam int unsigned ADDR_W = 4;

  localparam logic [15:0] MIN_GAP_RST  = 16'd500;
  localparam logic [15:0] EXPIRE_RST   = 16'd2000;
  localparam logic [7:0]  VWINDOW_RST  = 8'd10;
  localparam logic [6:0]  MAX_KICK_RST = 7'd5;

  localparam logic [13:0] US10_PER_MS  = 14'd100;
  localparam logic [11:0] TICKS_MAX    = 12'hFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] duration_us10;
    logic [7:0]  target_voltage;
    logic [7:0]  capacitor_voltage;
    logic        booster_ready;
  } in_t;

  typedef struct packed {
    logic        kick_active;
    logic        booster_enabled;
    logic        fired;
    logic [11:0] pulse_ticks;
    logic        clamped;
    logic        expired;
    logic        voltage_refused;
    logic        job_pending;
  } out_t;

  typedef struct packed {
    logic [15:0] min_gap_ms;
    logic [15:0] expire_ms;
    logic [7:0]  voltage_window;
    logic [6:0]  max_kick_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        job_valid;
    logic [31:0] job_time;
    logic [15:0] job_length;
    logic [7:0]  wait_voltage;
    logic [31:0] last_kick_time;
    logic [11:0] pulse_left;
    logic        firing;
  } state_t;

endpackage

// ===== src/kjpc_step.sv =====
module kjpc_step (
  input  kjpc_pkg::state_t st,
  input  kjpc_pkg::cfg_t   cfg,
  input  kjpc_pkg::in_t    item,
  output kjpc_pkg::state_t st_nxt,
  output kjpc_pkg::out_t   res
);

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d;
  endfunction

  logic [31:0] now_inc;
  logic [7:0]  half;
  logic        in_gap;
  logic        too_old;
  logic        volt_far;
  logic        target_far;
  logic [13:0] lim;
  logic        over_lim;
  logic [15:0] len_c;
  logic [18:0] len_x5;
  logic [15:0] ticks_full;
  logic [11:0] ticks;

  assign now_inc    = st.now_ms + 32'd1;
  assign half       = {1'b0, cfg.voltage_window[7:1]};
  assign in_gap     = (now_inc - st.last_kick_time) < {16'd0, cfg.min_gap_ms};
  assign too_old    = (now_inc - st.job_time) > {16'd0, cfg.expire_ms};
  assign volt_far   = abs_diff(st.wait_voltage, item.capacitor_voltage) > half;
  assign target_far = abs_diff(item.target_voltage, item.capacitor_voltage) > half;

  // duration limit in 10 us units, then floor(len*5/8) ticks of 16 us
  assign lim        = {7'd0, cfg.max_kick_ms} * kjpc_pkg::US10_PER_MS;
  assign over_lim   = st.job_length > {2'b00, lim};
  assign len_c      = over_lim ? {2'b00, lim} : st.job_length;
  assign len_x5     = {1'b0, len_c, 2'b00} + {3'b000, len_c};
  assign ticks_full = len_x5[18:3];
  assign ticks      = (ticks_full > {4'd0, kjpc_pkg::TICKS_MAX}) ?
                      kjpc_pkg::TICKS_MAX : ticks_full[11:0];

  always_comb begin
    logic go;
    kjpc_pkg::out_t r;
    st_nxt = st;
    r      = '0;
    go     = 1'b0;
    case (item.operation)
      kjpc_pkg::OP_MS_TICK: begin
        st_nxt.now_ms = now_inc;
        if (!st.firing && st.job_valid) begin
          go = 1'b1;
          if (in_gap) begin
            st_nxt.job_valid = 1'b0;
            go = 1'b0;
          end else if (too_old) begin
            st_nxt.job_valid = 1'b0;
            r.expired = 1'b1;
            go = 1'b0;
          end else if (st.wait_voltage != 8'd0) begin
            if (volt_far) begin
              go = 1'b0;
            end else begin
              st_nxt.wait_voltage = 8'd0;
            end
          end
          if (go && item.booster_ready) begin
            st_nxt.job_valid = 1'b0;
            r.fired       = 1'b1;
            r.pulse_ticks = ticks;
            r.clamped     = over_lim;
            if (ticks != 12'd0) begin
              st_nxt.firing     = 1'b1;
              st_nxt.pulse_left = ticks;
            end else begin
              // zero-length kick ends on the spot
              st_nxt.firing         = 1'b0;
              st_nxt.pulse_left     = 12'd0;
              st_nxt.last_kick_time = now_inc;
            end
          end
        end
      end
      kjpc_pkg::OP_KICK: begin
        st_nxt.job_valid  = 1'b1;
        st_nxt.job_time   = st.now_ms;
        st_nxt.job_length = item.duration_us10;
      end
      kjpc_pkg::OP_FORCED: begin
        if (target_far) begin
          r.voltage_refused = 1'b1;
        end else begin
          st_nxt.job_valid    = 1'b1;
          st_nxt.job_time     = st.now_ms;
          st_nxt.job_length   = item.duration_us10;
          st_nxt.wait_voltage = item.target_voltage;
        end
      end
      kjpc_pkg::OP_PULSE_TICK: begin
        if (st.firing) begin
          if (st.pulse_left <= 12'd1) begin
            st_nxt.firing         = 1'b0;
            st_nxt.pulse_left     = 12'd0;
            st_nxt.last_kick_time = st.now_ms;
          end else begin
            st_nxt.pulse_left = st.pulse_left - 12'd1;
          end
        end
      end
      default: begin
        st_nxt = st;
      end
    endcase
    r.kick_active     = st_nxt.firing;
    r.booster_enabled = !st_nxt.firing;
    r.job_pending     = st_nxt.job_valid;
    res = r;
  end

endmodule

// ===== src/kick_job_pulse_controller_core.sv =====
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   in_data  (kjpc_pkg::in_t)
// out      out  out_valid/out_stall out_data (kjpc_pkg::out_t)
// cfg      in   psel/penable/pready paddr, pwdata, prdata (32 bit)
//
// one beat per cycle sustained while out_stall is low; a beat passes the input register, then the result register
// the whole state update for a beat is one pass of kjpc_step into the state registers
// rst_n is synchronous: state clears, registers take their defaults
// out_stall holds the result register; one more beat waits in the input register,
// after which in_stall rises
module kick_job_pulse_controller_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  kjpc_pkg::in_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output kjpc_pkg::out_t                out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kjpc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  kjpc_pkg::cfg_t   cfg_r;
  kjpc_pkg::state_t st_r;
  kjpc_pkg::state_t st_nxt;
  kjpc_pkg::in_t    in_r;
  kjpc_pkg::out_t   out_r;
  kjpc_pkg::out_t   res;
  logic             stage_valid_r;
  logic             stage_valid_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             advance;
  logic             process;
  logic             in_take;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  assign advance  = !out_valid_r || !out_stall;
  assign process  = stage_valid_r && advance;
  assign in_stall = stage_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign stage_valid_nxt = in_take || (stage_valid_r && !advance);
  assign out_valid_nxt   = process || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  kjpc_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      st_r          <= '0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (process) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
    if (process) begin
      out_r <= res;
    end
  end

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_gap_ms     <= kjpc_pkg::MIN_GAP_RST;
      cfg_r.expire_ms      <= kjpc_pkg::EXPIRE_RST;
      cfg_r.voltage_window <= kjpc_pkg::VWINDOW_RST;
      cfg_r.max_kick_ms    <= kjpc_pkg::MAX_KICK_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        kjpc_pkg::REG_MIN_GAP:  cfg_r.min_gap_ms     <= pwdata[15:0];
        kjpc_pkg::REG_EXPIRE:   cfg_r.expire_ms      <= pwdata[15:0];
        kjpc_pkg::REG_VWINDOW:  cfg_r.voltage_window <= pwdata[7:0];
        kjpc_pkg::REG_MAX_KICK: cfg_r.max_kick_ms    <= pwdata[6:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kjpc_pkg::REG_MIN_GAP:  prdata = {16'd0, cfg_r.min_gap_ms};
      kjpc_pkg::REG_EXPIRE:   prdata = {16'd0, cfg_r.expire_ms};
      kjpc_pkg::REG_VWINDOW:  prdata = {24'd0, cfg_r.voltage_window};
      kjpc_pkg::REG_MAX_KICK: prdata = {25'd0, cfg_r.max_kick_ms};
      default:                prdata = 32'd0;
    endcase
  end

  // a pulse runs exactly while ticks remain
  a_firing_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.firing == (st_r.pulse_left != 12'd0))
    else $error("firing flag and pulse count disagree");

  a_drive_booster: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.kick_active != out_r.booster_enabled))
    else $error("booster enabled during kick drive");

  a_fire_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.fired) |-> (out_r.kick_active == (out_r.pulse_ticks != 12'd0)))
    else $error("started pulse and drive level disagree");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && stage_valid_r))
    else $error("input stalled with room in the pipeline");

  a_held_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_valid_r && !advance) |=> (stage_valid_r && $stable(in_r)))
    else $error("waiting beat lost from input register");

endmodule
